@@ hw/rtl/drp_pkg.sv @@
// ----------------------------------------------------------------------------
// Dead reckoning predictor package
// Shared widths, codes and state type for the predictor and its serial units.
// ----------------------------------------------------------------------------
package drp_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int CW            = 32;              // coordinate width
    localparam int TW            = 32;              // timestamp width
    localparam int FRAC          = 16;              // fractional bits of time
    localparam int DIVW          = CW + 1 + FRAC;   // dividend / quotient width
    localparam int PRODW         = DIVW + TW;       // full speed * time product
    localparam int MAGW          = CW + 2;          // capped displacement width
    localparam int SUMW          = CW + 3;          // position plus displacement
    localparam int CNTW          = $clog2(HISTORY_DEPTH + 1);

    localparam logic [PRODW-1:0] MAG_CAP = PRODW'(1) << (CW + 1);
    localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);

    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CFG_SEND_RATE = 1'b0;
    localparam logic CFG_PRED_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic div_start;
        logic mul_start;
        logic res_wr;
    } t_seq_ctrl;

endpackage

@@ hw/rtl/drp_if.sv @@
// ----------------------------------------------------------------------------
// Dead reckoning predictor channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface drp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_look_x;
    logic signed [31:0] in_look_y;
    logic [31:0] stamp;

    modport source (output valid, command, in_x, in_y, in_look_x, in_look_y, stamp,
                    input ready);
    modport sink   (input valid, command, in_x, in_y, in_look_x, in_look_y, stamp,
                    output ready);
endinterface

interface drp_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_look_x;
    logic signed [31:0] out_look_y;

    modport source (output valid, accepted, out_x, out_y, out_look_x, out_look_y,
                    input ready);
    modport sink   (input valid, accepted, out_x, out_y, out_look_x, out_look_y,
                    output ready);
endinterface

@@ hw/rtl/dead_reckoning_predictor_top.sv @@
// ----------------------------------------------------------------------------
// Dead reckoning predictor
// Stores position messages and extrapolates the shown position on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries messages (command 0) and display ticks (command 1); each
//   transfer gives exactly one result on o_result. Config is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
//   block is idle, as the block itself does not enforce this. Messages and
//   ticks that do not extrapolate pass from the idle state through ST_DONE
//   into the output register. A tick whose two newest messages share a time
//   skips the serial units. An extrapolating tick runs x then y through one
//   serial divider and one serial multiplier; the divider bit loop takes the
//   longest. Ready is high only while the sequencer is idle and out of reset.
//   No prediction history is kept: the second extrapolation would run from
//   the newest prediction to its own time, so it equals the first and the
//   midpoint of the two is simply the first.
//   A result waiting in the output register does not block the next input
//   transfer; the sequencer holds its finished result until the register
//   frees up when the receiver stalls.
//   Reset empties the history, clears the shown position and look point,
//   sets send_rate to 0 and turns prediction on.
// ----------------------------------------------------------------------------
module dead_reckoning_predictor_top
    import drp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    drp_in_if.sink      i_item,
    drp_out_if.source   o_result
);
    t_state r_state, n_state;
    t_seq_ctrl ctrl;

    logic [TW-1:0]          r_send_rate;
    logic                   r_mode;
    logic signed [CW-1:0]   r_rx0, r_rx1, r_ry0, r_ry1;
    logic [TW-1:0]          r_t0, r_t1;
    logic [CNTW-1:0]        r_count;
    logic signed [31:0]     r_look_x, r_look_y;
    logic signed [CW-1:0]   r_shown_x, r_shown_y;
    logic signed [CW-1:0]   r_px;
    logic [TW-1:0]          r_tick;
    logic                   r_axis;
    logic                   r_acc;
    logic                   r_ov;

    logic                   in_xfer, out_free, fresh;
    logic signed [CW-1:0]   fp, lp;
    logic signed [CW:0]     dp;
    logic signed [TW:0]     dt, ts;
    logic [CW:0]            ad;
    logic [TW-1:0]          at, as_mag;
    logic                   neg, dt_zero;
    logic                   div_done, mul_done;
    logic [DIVW-1:0]        quot;
    logic [PRODW-1:0]       prod, pshift;
    logic [MAGW-1:0]        mcap;
    logic signed [SUMW-1:0] sum;
    logic signed [CW-1:0]   res;

    assign in_xfer  = i_item.valid && i_item.ready;
    assign out_free = !r_ov || o_result.ready;
    assign i_item.ready = i_rst_n && (r_state == ST_IDLE);
    assign fresh = (r_count == '0) ||
                   ({1'b0, i_item.stamp} > ({1'b0, r_t0} + {1'b0, r_send_rate}));

    // operands of the axis in progress
    assign fp = r_axis ? r_ry0 : r_rx0;
    assign lp = r_axis ? r_ry1 : r_rx1;
    assign dp = (CW+1)'(fp) - (CW+1)'(lp);
    assign dt = $signed({1'b0, r_t0}) - $signed({1'b0, r_t1});
    assign ts = $signed({1'b0, r_tick}) - $signed({1'b0, r_t0});
    assign ad = dp[CW] ? (CW+1)'(-dp) : dp;
    assign at = dt[TW] ? TW'(-dt) : dt[TW-1:0];
    assign as_mag = ts[TW] ? TW'(-ts) : ts[TW-1:0];
    assign neg = dp[CW] ^ dt[TW] ^ ts[TW];
    assign dt_zero = (dt == '0);

    drp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (ad),
        .i_divisor  (at),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    drp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.mul_start),
        .i_a     (quot),
        .i_b     (as_mag),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // cap the displacement, apply it and saturate
    assign pshift = prod >> FRAC;
    assign mcap = (pshift > MAG_CAP) ? MAG_CAP[MAGW-1:0] : pshift[MAGW-1:0];
    always_comb begin
        sum = neg ? SUMW'(fp) - $signed(SUMW'(mcap)) : SUMW'(fp) + $signed(SUMW'(mcap));
        if (dt_zero) begin
            res = fp;
        end else if (sum > CMAX) begin
            res = CMAX[CW-1:0];
        end else if (sum < CMIN) begin
            res = CMIN[CW-1:0];
        end else begin
            res = sum[CW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_item.command == CMD_TICK && r_count != '0 && r_mode &&
                        r_count >= CNTW'(HISTORY_DEPTH)) begin
                        n_state = ST_AXIS;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_AXIS: begin
                if (dt_zero) begin
                    n_state = r_axis ? ST_DONE : ST_AXIS;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = r_axis ? ST_DONE : ST_AXIS;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.div_start = (r_state == ST_AXIS) && !dt_zero;
        ctrl.mul_start = (r_state == ST_DIV) && div_done;
        ctrl.res_wr    = ((r_state == ST_AXIS) && dt_zero) ||
                         ((r_state == ST_MUL) && mul_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_send_rate <= '0;
            r_mode      <= 1'b1;
            r_count     <= '0;
            r_look_x    <= '0;
            r_look_y    <= '0;
            r_shown_x   <= '0;
            r_shown_y   <= '0;
            r_axis      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEND_RATE: r_send_rate <= i_cfg_data;
                    CFG_PRED_MODE: r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_axis <= 1'b0;
                if (i_item.command == CMD_MSG) begin
                    if (fresh) begin
                        r_look_x <= i_item.in_look_x;
                        r_look_y <= i_item.in_look_y;
                        if (r_count < CNTW'(HISTORY_DEPTH)) begin
                            r_count <= r_count + CNTW'(1);
                        end
                    end
                end else if (r_count != '0 && !r_mode) begin
                    r_shown_x <= r_rx0;
                    r_shown_y <= r_ry0;
                end
            end
            if (ctrl.res_wr) begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_shown_x <= r_px;
                    r_shown_y <= res;
                end
            end
            // load the output register, drop it once transferred
            if (r_state == ST_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_acc  <= (i_item.command == CMD_MSG) && fresh;
            r_tick <= i_item.stamp;
            if (i_item.command == CMD_MSG && fresh) begin
                r_rx1 <= r_rx0;
                r_ry1 <= r_ry0;
                r_t1  <= r_t0;
                r_rx0 <= i_item.in_x;
                r_ry0 <= i_item.in_y;
                r_t0  <= i_item.stamp;
            end
        end
        if (ctrl.res_wr && !r_axis) begin
            r_px <= res;
        end
        if (r_state == ST_DONE && out_free) begin
            o_result.accepted   <= r_acc;
            o_result.out_x      <= r_shown_x;
            o_result.out_y      <= r_shown_y;
            o_result.out_look_x <= r_look_x;
            o_result.out_look_y <= r_look_y;
        end
    end

    assign o_result.valid = r_ov;
endmodule

@@ hw/rtl/drp_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, dividend scaled by 2^FRAC.
// ----------------------------------------------------------------------------
module drp_div
    import drp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [CW:0]     i_dividend,
    input  logic [TW-1:0]   i_divisor,
    output logic            o_done,
    output logic [DIVW-1:0] o_quot
);
    localparam int DCW = $clog2(DIVW);
    localparam logic [DCW-1:0] LAST = DCW'(DIVW - 1);

    logic            r_busy;
    logic [DCW-1:0]  r_cnt;
    logic [TW-1:0]   r_rem;
    logic [TW-1:0]   r_div;
    logic [DIVW-1:0] r_num;
    logic            r_done;
    logic [TW:0]     trial;
    logic            fits;

    assign trial = {r_rem, r_num[DIVW-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_num <= {i_dividend, {FRAC{1'b0}}};
        end else if (r_busy) begin
            // remainder stays below the divisor, so TW bits hold it
            r_rem <= fits ? TW'(trial - {1'b0, r_div}) : trial[TW-1:0];
            r_num <= {r_num[DIVW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

@@ hw/rtl/drp_mul.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module drp_mul
    import drp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIVW-1:0]  i_a,
    input  logic [TW-1:0]    i_b,
    output logic             o_done,
    output logic [PRODW-1:0] o_prod
);
    localparam int MCW = $clog2(TW);
    localparam logic [MCW-1:0] LAST = MCW'(TW - 1);

    logic             r_busy;
    logic             r_done;
    logic [MCW-1:0]   r_cnt;
    logic [PRODW-1:0] r_acc;
    logic [PRODW-1:0] r_a;
    logic [TW-1:0]    r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MCW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PRODW'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ sim/dead_reckoning_predictor_top_tb.sv @@
// ----------------------------------------------------------------------------
// Dead reckoning predictor testbench
// Drives position messages and display ticks into the predictor with random
// gaps on both channels, and checks every result against a local model of the
// history, the linear extrapolation and the blend of the two predictions.
// ----------------------------------------------------------------------------
module dead_reckoning_predictor_top_tb
    import drp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           WATCHDOG_LIMIT = 20000;
    localparam int           SETTLE_CYCLES  = 400;
    localparam longint       POS_MAX        = 64'sd2147483647;
    localparam longint       POS_MIN        = -64'sd2147483648;
    localparam longint unsigned DISP_CAP    = 64'd1 << 33;

    typedef struct {
        logic        command;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] look_x;
        logic [31:0] look_y;
        logic [31:0] stamp;
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] look_x;
        logic [31:0] look_y;
    } t_result;

    typedef struct {
        t_item   item;
        bit      known;
        t_result res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_SEND_RATE;
    logic [31:0] i_cfg_data = '0;

    drp_in_if  item_ch ();
    drp_out_if result_ch ();

    dead_reckoning_predictor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // model state
    logic [31:0] rate_q16;
    logic        extrap_on;
    longint      hist_x [HISTORY_DEPTH];
    longint      hist_y [HISTORY_DEPTH];
    logic [31:0] hist_t [HISTORY_DEPTH];
    int          hist_n;
    longint      guess_x [HISTORY_DEPTH];
    longint      guess_y [HISTORY_DEPTH];
    logic [31:0] guess_t [HISTORY_DEPTH];
    int          guess_n;
    longint      shown_x, shown_y, look_x, look_y;

    t_result     pending_results [$];
    int          n_sent, n_checked, n_errors, n_ticks, n_stored, idle_cycles;
    bit          cur_known;
    t_result     cur_typed;
    bit          gaps_on;
    bit          hold_done;

    function automatic longint extrapolate(longint newer, longint older, logic [31:0] t_newer,
                                           logic [31:0] t_older, logic [31:0] t_now);
        longint dt, dp, ts;
        longint unsigned mdp, mdt, span, quo, rem, speed, disp;
        bit neg;
        longint res;
        dt = $signed({32'd0, t_newer}) - $signed({32'd0, t_older});
        if (dt == 0) return newer;
        dp = newer - older;
        ts = $signed({32'd0, t_now}) - $signed({32'd0, t_newer});
        neg = ((dp < 0) != (dt < 0)) != (ts < 0);
        mdp = (dp < 0) ? -dp : dp;
        mdt = (dt < 0) ? -dt : dt;
        span = (ts < 0) ? -ts : ts;
        quo = mdp / mdt;
        rem = mdp % mdt;
        if (quo >= (64'd1 << 46)) speed = 64'd1 << 62;
        else speed = (quo << 16) + ((rem << 16) / mdt);
        if (speed == 0 || span == 0) disp = 0;
        else if (speed > ({64{1'b1}} / span)) disp = DISP_CAP;
        else disp = (speed * span) >> 16;
        if (disp > DISP_CAP) disp = DISP_CAP;
        res = neg ? newer - longint'(disp) : newer + longint'(disp);
        if (res > POS_MAX) res = POS_MAX;
        if (res < POS_MIN) res = POS_MIN;
        return res;
    endfunction

    function automatic t_result predict_result(t_item it);
        t_result r;
        longint px, py, hx, hy;
        r.accepted = 1'b0;
        if (it.command == CMD_MSG) begin
            if (hist_n == 0 || {1'b0, it.stamp} > ({1'b0, hist_t[0]} + {1'b0, rate_q16})) begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                    hist_x[i] = hist_x[i-1];
                    hist_y[i] = hist_y[i-1];
                    hist_t[i] = hist_t[i-1];
                end
                hist_x[0] = longint'($signed(it.x));
                hist_y[0] = longint'($signed(it.y));
                hist_t[0] = it.stamp;
                look_x = longint'($signed(it.look_x));
                look_y = longint'($signed(it.look_y));
                if (hist_n < HISTORY_DEPTH) hist_n++;
                r.accepted = 1'b1;
            end
        end else if (hist_n != 0) begin
            if (!extrap_on) begin
                shown_x = hist_x[0];
                shown_y = hist_y[0];
            end else if (hist_n >= HISTORY_DEPTH) begin
                px = extrapolate(hist_x[0], hist_x[1], hist_t[0], hist_t[1], it.stamp);
                py = extrapolate(hist_y[0], hist_y[1], hist_t[0], hist_t[1], it.stamp);
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                    guess_x[i] = guess_x[i-1];
                    guess_y[i] = guess_y[i-1];
                    guess_t[i] = guess_t[i-1];
                end
                guess_x[0] = px;
                guess_y[0] = py;
                guess_t[0] = it.stamp;
                if (guess_n < HISTORY_DEPTH) guess_n++;
                if (guess_n >= HISTORY_DEPTH) begin
                    hx = extrapolate(guess_x[0], guess_x[1], guess_t[0], guess_t[1], it.stamp);
                    hy = extrapolate(guess_y[0], guess_y[1], guess_t[0], guess_t[1], it.stamp);
                    px = px + (hx - px) / 2;
                    py = py + (hy - py) / 2;
                end
                shown_x = px;
                shown_y = py;
            end
        end
        r.x = shown_x[31:0];
        r.y = shown_y[31:0];
        r.look_x = look_x[31:0];
        r.look_y = look_y[31:0];
        return r;
    endfunction

    // input transfers: advance the model and queue the expectation
    always @(posedge i_clk) begin
        t_item   it;
        t_result r;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            it.command = item_ch.command;
            it.x = item_ch.in_x;
            it.y = item_ch.in_y;
            it.look_x = item_ch.in_look_x;
            it.look_y = item_ch.in_look_y;
            it.stamp = item_ch.stamp;
            r = predict_result(it);
            if (cur_known && r != cur_typed) begin
                $display("%0t: table row %0d typed %h, model gives %h", $realtime, n_sent,
                         cur_typed, r);
                n_errors++;
            end
            pending_results.insert(pending_results.size(), cur_known ? cur_typed : r);
            if (it.command == CMD_TICK) n_ticks++;
            if (r.accepted) n_stored++;
            n_sent++;
        end
    end

    // result transfers
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result acc=%0b x=%h y=%h", $realtime,
                         result_ch.accepted, result_ch.out_x, result_ch.out_y);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.accepted !== result_ch.accepted) begin
                    $display("%0t: accepted exp %0b got %0b", $realtime, e.accepted,
                             result_ch.accepted);
                    n_errors++;
                end
                if (e.x !== result_ch.out_x) begin
                    $display("%0t: out_x exp %h got %h", $realtime, e.x, result_ch.out_x);
                    n_errors++;
                end
                if (e.y !== result_ch.out_y) begin
                    $display("%0t: out_y exp %h got %h", $realtime, e.y, result_ch.out_y);
                    n_errors++;
                end
                if (e.look_x !== result_ch.out_look_x) begin
                    $display("%0t: out_look_x exp %h got %h", $realtime, e.look_x,
                             result_ch.out_look_x);
                    n_errors++;
                end
                if (e.look_y !== result_ch.out_look_y) begin
                    $display("%0t: out_look_y exp %h got %h", $realtime, e.look_y,
                             result_ch.out_look_y);
                    n_errors++;
                end
            end
            n_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("** dead_reckoning_predictor_top: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // receiver: random stalls, one long hold-off to fill the block
    initial begin
        int stall;
        result_ch.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_checked >= 400) begin
                hold_done = 1'b1;
                stall = 900;
            end
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else begin
                stall = pick_gap();
                result_ch.ready <= (stall == 0);
            end
        end
    end

    task automatic send_item(t_item it, bit known = 1'b0, t_result typed = '{default: '0});
        int gap;
        int target;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= it.command;
        item_ch.in_x <= it.x;
        item_ch.in_y <= it.y;
        item_ch.in_look_x <= it.look_x;
        item_ch.in_look_y <= it.look_y;
        item_ch.stamp <= it.stamp;
        cur_known = known;
        cur_typed = typed;
        target = n_sent + 1;
        do @(negedge i_clk); while (n_sent < target);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        item_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge i_clk);
        // let the block settle back to idle
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SEND_RATE) rate_q16 = data;
        else extrap_on = data[0];
    endtask

    logic [31:0] clock_q16;
    logic [31:0] last_tick;
    logic [31:0] walk_x, walk_y;

    task automatic run_random(int count);
        t_item it;
        int r;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) gaps_on = ($urandom_range(3) != 0);
            r = $urandom_range(99);
            it.look_x = $urandom;
            it.look_y = $urandom;
            if (r < 8) begin
                // noise tick: every field random, stamp included
                it.command = CMD_TICK;
                it.x = $urandom;
                it.y = $urandom;
                it.stamp = $urandom;
            end else if (r < 50) begin
                it.command = CMD_MSG;
                clock_q16 += $urandom_range(32'h20000, 1);
                if ($urandom_range(19) == 0) begin
                    walk_x = $urandom;
                    walk_y = $urandom;
                end else begin
                    walk_x += $urandom_range(32'h80000) - 32'h40000;
                    walk_y += $urandom_range(32'h80000) - 32'h40000;
                end
                it.x = walk_x;
                it.y = walk_y;
                // sometimes resend an older time so the message can be stale
                it.stamp = ($urandom_range(9) == 0) ? clock_q16 - $urandom_range(32'h10000)
                                                    : clock_q16;
            end else begin
                it.command = CMD_TICK;
                it.x = $urandom;
                it.y = $urandom;
                r = $urandom_range(19);
                if (r < 2) it.stamp = last_tick;
                else if (r < 3) it.stamp = clock_q16 - $urandom_range(32'h40000);
                else it.stamp = clock_q16 + $urandom_range(32'h20000);
                last_tick = it.stamp;
            end
            send_item(it);
        end
    endtask

    t_row directed [$];

    function automatic t_row row(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] lx,
                                 logic [31:0] ly, logic [31:0] st, bit known = 1'b0,
                                 logic acc = 1'b0, logic [31:0] ex = '0, logic [31:0] ey = '0,
                                 logic [31:0] elx = '0, logic [31:0] ely = '0);
        t_row r;
        r.item = '{cmd, x, y, lx, ly, st};
        r.known = known;
        r.res = '{acc, ex, ey, elx, ely};
        return r;
    endfunction

    function automatic void add_row(t_row r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        item_ch.valid = 1'b0;
        item_ch.command = CMD_MSG;
        item_ch.in_x = '0;
        item_ch.in_y = '0;
        item_ch.in_look_x = '0;
        item_ch.in_look_y = '0;
        item_ch.stamp = '0;
        rate_q16 = '0;
        extrap_on = 1'b1;
        hist_n = 0;
        guess_n = 0;
        shown_x = 0; shown_y = 0; look_x = 0; look_y = 0;
        n_sent = 0; n_checked = 0; n_errors = 0; n_ticks = 0; n_stored = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        hold_done = 1'b0;
        cur_known = 1'b0;

        // tick on an empty history, then saturating and zero-gap cases
        add_row(row(CMD_TICK, '1, '1, '1, '1, 32'h0001_0000, 1, 0, 0, 0, 0, 0));
        add_row(row(CMD_MSG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0001_0000, 1, 1, 0, 0,
                    32'h8000_0000, 32'h7FFF_FFFF));
        add_row(row(CMD_MSG, 1, 2, 3, 4, 32'h0001_0000, 1, 0, 0, 0,
                    32'h8000_0000, 32'h7FFF_FFFF));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0005_0000, 1, 0, 0, 0,
                    32'h8000_0000, 32'h7FFF_FFFF));
        add_row(row(CMD_MSG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h0001_0001));
        add_row(row(CMD_MSG, 32'h7FFF_FFFF, 32'h8000_0000, 5, 6, 32'h0001_0002));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0000_0000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0000_0000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0000_0000));
        add_row(row(CMD_MSG, 32'h0001_0000, 32'hFFFF_0000, 7, 8, 32'h0002_0000));
        add_row(row(CMD_MSG, 32'h0002_0000, 32'hFFFE_0000, 9, 10, 32'h0003_0000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0003_8000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0004_0000));
        add_row(row(CMD_TICK, '1, '1, '1, '1, 32'h0004_8000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0002_0000));
        add_row(row(CMD_MSG, 32'h0003_0000, 32'hFFFD_0000, 11, 12, 32'h0004_0000));
        add_row(row(CMD_TICK, 0, 0, 0, 0, 32'h0005_0000));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_item(directed[i].item, directed[i].known, directed[i].res);

        clock_q16 = 32'h0010_0000;
        last_tick = clock_q16;
        walk_x = '0;
        walk_y = '0;
        run_random(450);
        write_reg(CFG_SEND_RATE, 32'h0000_8000);
        run_random(350);
        write_reg(CFG_PRED_MODE, 32'd0);
        run_random(250);
        write_reg(CFG_SEND_RATE, 32'hFFFF_FFFF);
        run_random(60);
        write_reg(CFG_SEND_RATE, 32'h0000_0200);
        write_reg(CFG_PRED_MODE, 32'd1);
        run_random(300);

        // newest time plus send rate overflows 32 bits: every later message is stale
        send_item('{CMD_MSG, 32'h1234_0000, 32'h4321_0000, 1, 2, 32'hFFFF_FF00});
        send_item('{CMD_MSG, 32'h0, 32'h0, 3, 4, 32'hFFFF_FFFF});
        send_item('{CMD_TICK, 32'h0, 32'h0, 0, 0, 32'hFFFF_FFFF});
        item_ch.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Run: %0d transfers in (%0d ticks, %0d messages stored), %0d results checked",
                 n_sent, n_ticks, n_stored, n_checked);
        $display("Covered both prediction modes and send rates 0, 0x8000, 0x200 and all ones");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("** dead_reckoning_predictor_top: PASSED **");
        end else begin
            $display("** dead_reckoning_predictor_top: FAILED **");
        end
        $finish;
    end

endmodule
